FILE: hdl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Types and constants shared by the co-assignment similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  localparam int ProbW  = 17;
  localparam int RowW   = 10;
  localparam int SlotW  = 4;
  localparam int CountW = 5;

  // Q1.16 one
  localparam logic [ProbW-1:0]  OneQ16         = 17'h10000;
  localparam logic [CountW-1:0] NumClustersRst = 5'd1;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_DOT   = 2'd1,
    CMD_UNIT  = 2'd2
  } cmd_e;

  typedef struct packed {
    op_e               operation;
    logic [RowW-1:0]   row_index;
    logic [RowW-1:0]   other_row;
    logic [SlotW-1:0]  cluster_index;
    logic [ProbW-1:0]  probability;
  } in_item_t;

  typedef struct packed {
    logic [ProbW-1:0] similarity;
    logic             same_row;
  } out_item_t;

  // Classified work passed from the front to the back end
  typedef struct packed {
    cmd_e              kind;
    logic [RowW-1:0]   row_a;
    logic [RowW-1:0]   row_b;
    logic              a_ok;
    logic              b_ok;
    logic [SlotW-1:0]  slot;
    logic [ProbW-1:0]  prob;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/cas_fifo.sv
// ----------------------------------------------------------------------------
// cas_fifo
// Two-entry queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_fifo #(
  parameter int Width = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

FILE: hdl/cas_front.sv
// ----------------------------------------------------------------------------
// cas_front
// Input stage: takes items, sorts them into store writes, dot products and
// same-row answers, and drops loads that fall outside the store.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_front #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire cas_pkg::in_item_t item_i,
  output logic                   cmd_push_o,
  output cas_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_full_i
);

  import cas_pkg::*;

  cmd_t cmd_q, cls;
  logic vld_q;
  logic accept, keep;

  assign full       = vld_q && cmd_full_i;
  assign accept     = push && !full;
  assign cmd_push_o = vld_q;
  assign cmd_o      = cmd_q;

  always_comb begin
    cls.row_a = item_i.row_index;
    cls.row_b = item_i.other_row;
    cls.a_ok  = (32'(item_i.row_index) < MAX_ROWS);
    cls.b_ok  = (32'(item_i.other_row) < MAX_ROWS);
    cls.slot  = item_i.cluster_index;
    cls.prob  = (item_i.probability > OneQ16) ? OneQ16 : item_i.probability;
    keep      = 1'b1;
    if (item_i.operation == OP_LOAD) begin
      cls.kind = CMD_WRITE;
      keep     = cls.a_ok && (32'(item_i.cluster_index) < MAX_CLUSTERS);
    end else if (item_i.row_index == item_i.other_row) begin
      cls.kind = CMD_UNIT;
    end else begin
      cls.kind = CMD_DOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= keep;
    end else if (!cmd_full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cls;
  end

endmodule

`default_nettype wire

FILE: hdl/cas_back.sv
// ----------------------------------------------------------------------------
// cas_back
// Execution stage: owns the probability store, performs writes and runs the
// dot product one cluster pair per cycle through a read/multiply/add pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_back #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cas_pkg::CountW-1:0]  num_clusters_i,
  input  wire logic                        cmd_empty_i,
  input  wire cas_pkg::cmd_t               cmd_i,
  output logic                             cmd_pop_o,
  input  wire logic                        out_full_i,
  output logic                             out_push_o,
  output cas_pkg::out_item_t               out_item_o
);

  import cas_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_CLUSTERS;
  localparam int AddrW = $clog2(Depth);
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int AccW  = 34 + $clog2(MAX_CLUSTERS);
  localparam int RndW  = AccW + 1 - 16;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  function automatic logic [AddrW-1:0] entry_addr(logic [RowW-1:0] row, logic [31:0] slot);
    logic [31:0] lin;
    lin = 32'(row) * 32'(MAX_CLUSTERS) + slot;
    return lin[AddrW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [RowW-1:0]   row_a_q, row_b_q;
  logic              a_ok_q, b_ok_q;
  logic [KW-1:0]     k_q, k_d, cnt_q, cnt_d, cnt_clamp;
  logic              rd_vld_q, mul_vld_q, issue, start;
  logic [ProbW-1:0]  mem_q [Depth];
  logic [ProbW-1:0]  rd_a_q, rd_b_q, op_a, op_b;
  logic [2*ProbW-1:0] prod_q;
  logic [AccW-1:0]   acc_q;
  logic [AccW:0]     rnd_sum;
  logic [RndW-1:0]   rnd;
  logic [ProbW-1:0]  sat;
  logic              we;
  logic [AddrW-1:0]  waddr, raddr_a, raddr_b;

  assign cnt_clamp = KW'((32'(num_clusters_i) > MAX_CLUSTERS) ? MAX_CLUSTERS
                                                              : 32'(num_clusters_i));
  assign issue   = (state_q == S_RUN) && (k_q != cnt_q);
  assign waddr   = entry_addr(cmd_i.row_a, 32'(cmd_i.slot));
  assign raddr_a = entry_addr(row_a_q, 32'(k_q));
  assign raddr_b = entry_addr(row_b_q, 32'(k_q));

  // round half up, then clamp at 1.0
  assign rnd_sum = {1'b0, acc_q} + (AccW+1)'(32768);
  assign rnd     = rnd_sum[AccW:16];
  assign sat     = (rnd > RndW'(OneQ16)) ? OneQ16 : rnd[ProbW-1:0];

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_item_o = '{similarity: sat, same_row: 1'b0};
    we         = 1'b0;
    start      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            CMD_WRITE: begin
              we        = 1'b1;
              cmd_pop_o = 1'b1;
            end
            CMD_UNIT: begin
              if (!out_full_i) begin
                out_push_o = 1'b1;
                out_item_o = '{similarity: OneQ16, same_row: 1'b1};
                cmd_pop_o  = 1'b1;
              end
            end
            CMD_DOT: begin
              cmd_pop_o = 1'b1;
              start     = 1'b1;
              k_d       = '0;
              cnt_d     = cnt_clamp;
              state_d   = S_RUN;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      S_RUN: begin
        if (issue) begin
          k_d = k_q + KW'(1);
        end else if (!rd_vld_q && !mul_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  // out-of-range rows read as zero
  assign op_a = a_ok_q ? rd_a_q : '0;
  assign op_b = b_ok_q ? rd_b_q : '0;

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_a_q <= cmd_i.row_a;
      row_b_q <= cmd_i.row_b;
      a_ok_q  <= cmd_i.a_ok;
      b_ok_q  <= cmd_i.b_ok;
    end
    prod_q <= op_a * op_b;
    if (start) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= cmd_i.prob;
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

endmodule

`default_nettype wire

FILE: hdl/co_assignment_similarity_unit.sv
// ----------------------------------------------------------------------------
// co_assignment_similarity_unit
// Load: front register, command queue, store write; front and back take one load
//   per cycle unless held by a full queue or a busy back end. Query: one cluster
//   pair read and multiplied per cycle over min(num_clusters, MAX_CLUSTERS) pairs.
// Reset clears control and sets num_clusters to 1; store contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module co_assignment_similarity_unit #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [cas_pkg::CountW-1:0] cfg_data_i,
  input  wire logic                       push,
  output logic                            full,
  input  wire cas_pkg::in_item_t          in_data_i,
  output logic                            empty,
  input  wire logic                       pop,
  output cas_pkg::out_item_t              out_data_o
);

  import cas_pkg::*;

  logic [CountW-1:0] num_clusters_q;
  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t              cmd_in, cmd_out;
  logic              res_push, res_full;
  out_item_t         res_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= NumClustersRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_clusters_q <= cfg_data_i;
    end
  end

  cas_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (in_data_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in),
    .cmd_full_i(cmd_full)
  );

  cas_fifo #(
    .Width($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  cas_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_clusters_i(num_clusters_q),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .out_full_i    (res_full),
    .out_push_o    (res_push),
    .out_item_o    (res_item)
  );

  cas_fifo #(
    .Width($bits(out_item_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire
